>>> hdl/clipped_rectangle_fill_framebuffer_defines.svh
// Assertion macros shared by the checker of the rectangle fill block.
`ifndef CLIPPED_RECTANGLE_FILL_FRAMEBUFFER_DEFINES_SVH
`define CLIPPED_RECTANGLE_FILL_FRAMEBUFFER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CRF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> hdl/crf_pkg.sv
// Shared types, codes and constants of the rectangle fill block.
package crf_pkg;

   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 256;

   localparam int HEIGHT_W    = 7;
   localparam int WIDTH_W     = 9;
   localparam int CHAR_W      = 8;
   localparam int COUNT_W     = 15;
   localparam int COORD_W     = 11;
   localparam int READ_ROW_W  = 6;
   localparam int READ_COL_W  = 8;
   localparam int CMP_W       = 12;

   localparam int REQ_TDATA_W = 72;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 7'd64;
   localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 9'd256;

   localparam int MIN_ROWS    = 3;
   localparam int MIN_COLS    = 1;
   localparam int WATER_ROWS  = 3;

   localparam logic [CHAR_W-1:0]  WATER_CHAR = 8'h7E;
   localparam logic [CHAR_W-1:0]  BLANK_CHAR = 8'h20;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 15'h7FFF;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_FILL  = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [0:0] {
      REG_MAP_HEIGHT = 1'b0,
      REG_MAP_WIDTH  = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_BOOT,
      ST_IDLE,
      ST_CULL,
      ST_FILL,
      ST_CLEAR,
      ST_READ,
      ST_DONE
   } state_type;

   // Controls from the sequencer to the cell walker.
   typedef struct packed {
      logic load;
      logic step;
      logic tally;
   } walk_ctl_type;

   // Status from the cell walker back to the sequencer.
   typedef struct packed {
      logic last;
   } walk_sts_type;

endpackage

>>> hdl/crf_store.sv
// Character frame store: one write port and one registered read port.
module crf_store
   import crf_pkg::*;
#(
   parameter int ADDR_W = 14
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [CHAR_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [CHAR_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [CHAR_W-1:0] mem [DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   // Write one cell per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/crf_walk.sv
// Cell walker: row and column counters, end compare and saturating cell tally.
module crf_walk
   import crf_pkg::*;
#(
   parameter int ROW_BW = 7,
   parameter int COL_BW = 9
) (
   input  logic               clock,
   input  walk_ctl_type       ctl,
   input  logic [ROW_BW-1:0]  row_first,
   input  logic [COL_BW-1:0]  col_first,
   input  logic [ROW_BW-1:0]  row_end,
   input  logic [COL_BW-1:0]  col_end,
   output logic [ROW_BW-1:0]  row,
   output logic [COL_BW-1:0]  col,
   output logic [COUNT_W-1:0] count,
   output walk_sts_type       sts
);

   logic [ROW_BW-1:0]  row_ff, row_in;
   logic [COL_BW-1:0]  col_ff, col_in;
   logic [COL_BW-1:0]  col_first_ff, col_first_in;
   logic [ROW_BW-1:0]  row_end_ff, row_end_in;
   logic [COL_BW-1:0]  col_end_ff, col_end_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ROW_BW-1:0]  row_next;
   logic [COL_BW-1:0]  col_next;
   logic               col_wrap;
   logic               row_wrap;

   // Shared increment and end compare
   always_comb begin
      row_next = row_ff + ROW_BW'(1);
      col_next = col_ff + COL_BW'(1);
      col_wrap = (col_next == col_end_ff);
      row_wrap = (row_next == row_end_ff);
      sts.last = col_wrap && row_wrap;
   end

   // Load bounds, or advance one cell in raster order
   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      col_first_in = col_first_ff;
      row_end_in   = row_end_ff;
      col_end_in   = col_end_ff;
      count_in     = count_ff;
      if (ctl.load) begin
         row_in       = row_first;
         col_in       = col_first;
         col_first_in = col_first;
         row_end_in   = row_end;
         col_end_in   = col_end;
         count_in     = '0;
      end else if (ctl.step) begin
         if (col_wrap) begin
            col_in = col_first_ff;
            row_in = row_next;
         end else begin
            col_in = col_next;
         end
         if (ctl.tally && (count_ff != COUNT_MAX)) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      col_first_ff <= col_first_in;
      row_end_ff   <= row_end_in;
      col_end_ff   <= col_end_in;
      count_ff     <= count_in;
   end

   assign row   = row_ff;
   assign col   = col_ff;
   assign count = count_ff;

endmodule

>>> hdl/clipped_rectangle_fill_framebuffer.sv
// Top level of the clipped rectangle fill block: sequencer, registers, ports.
//
// Usage: req_ takes one item at a time and rsp_ returns one result per item.
// The frame store has a single write port, so the cell walker writes one cell
// per cycle. A fill writes its clipped area (a culled fill writes none), and a
// clear sweeps the whole store of MAX_ROWS*MAX_COLS cells. After reset the
// block loads the walker and then runs the same sweep with req_tready low;
// csr_ writes are taken during it. A finished result waits in the output
// register while the next item is accepted. Configuration may change only
// while the block is idle.
module clipped_rectangle_fill_framebuffer
   import crf_pkg::*;
#(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata from bit 0: rect_left[10:0], rect_top[21:11], rect_right[32:22],
   // rect_bottom[43:33], brush_char[51:44], read_row[57:52], read_col[65:58],
   // zero fill[71:66]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: action[1:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   // rsp_tdata from bit 0: cell_char[7:0], rect_drawn[8], cells_written[23:9]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RBW = $clog2(MAX_ROWS + 1);
   localparam int CBW = $clog2(MAX_COLS + 1);
   localparam int AW  = RW + CW;

   localparam logic [CMP_W-1:0] ROWS_LO = CMP_W'(MIN_ROWS);
   localparam logic [CMP_W-1:0] ROWS_HI = CMP_W'(MAX_ROWS);
   localparam logic [CMP_W-1:0] COLS_LO = CMP_W'(MIN_COLS);
   localparam logic [CMP_W-1:0] COLS_HI = CMP_W'(MAX_COLS);

   function automatic logic [CMP_W-1:0] clamp(input logic [CMP_W-1:0] v,
                                              input logic [CMP_W-1:0] lo,
                                              input logic [CMP_W-1:0] hi);
      logic [CMP_W-1:0] r;
      r = v;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

   // Configuration registers and decode
   logic [HEIGHT_W-1:0] height_ff;
   logic [WIDTH_W-1:0]  width_ff;
   logic                csr_wr;
   reg_index_type       csr_idx;

   // Sequencer state and item registers
   state_type             state_ff, state_in;
   logic                  boot_ff;
   action_type            act_ff;
   logic signed [COORD_W-1:0] left_ff, top_ff, right_ff, bottom_ff;
   logic [CHAR_W-1:0]     brush_ff;
   logic [READ_ROW_W-1:0] rrow_ff;
   logic [READ_COL_W-1:0] rcol_ff;
   logic                  culled_ff;
   logic                  rd_ok_ff;
   logic [RBW-1:0]        clr_h_ff;
   logic [CBW-1:0]        clr_w_ff;
   logic                  rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   // Derived map and clip values
   logic [RBW-1:0]          h_use, h_rst;
   logic [CBW-1:0]          w_use, w_rst;
   logic signed [CMP_W-1:0] l_s, t_s, r_s, b_s, h_s, w_s;
   logic                    culled_c;
   logic [RBW-1:0]          ct_c, cb_c;
   logic [CBW-1:0]          cl_c, cr_c;
   logic                    rd_ok_c;
   action_type              req_act;
   logic                    req_fire;
   logic                    rsp_free;

   // Walker and store hookup
   walk_ctl_type      walk_ctl;
   walk_sts_type      walk_sts;
   logic [RBW-1:0]    walk_row, walk_row_first, walk_row_end;
   logic [CBW-1:0]    walk_col, walk_col_first, walk_col_end;
   logic [COUNT_W-1:0] walk_count;
   logic              clr_in_map;
   logic              clr_water;
   logic              wr_en;
   logic [CHAR_W-1:0] wr_data;
   logic              rd_en;
   logic [CHAR_W-1:0] rd_data;
   logic              rsp_load;
   logic [CHAR_W-1:0]  out_cell;
   logic               out_drawn;
   logic [COUNT_W-1:0] out_count;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= HEIGHT_RST;
         width_ff  <= WIDTH_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_MAP_HEIGHT: height_ff <= csr_pwdata[HEIGHT_W-1:0];
            REG_MAP_WIDTH:  width_ff  <= csr_pwdata[WIDTH_W-1:0];
            default:        height_ff <= height_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_MAP_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         REG_MAP_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Saturate the map size in use
   always_comb begin
      h_use = RBW'(clamp(CMP_W'(height_ff), ROWS_LO, ROWS_HI));
      w_use = CBW'(clamp(CMP_W'(width_ff), COLS_LO, COLS_HI));
      h_rst = RBW'(clamp(CMP_W'(HEIGHT_RST), ROWS_LO, ROWS_HI));
      w_rst = CBW'(clamp(CMP_W'(WIDTH_RST), COLS_LO, COLS_HI));
   end

   // Cull test and clip against the map
   always_comb begin
      l_s = CMP_W'(left_ff);
      t_s = CMP_W'(top_ff);
      r_s = CMP_W'(right_ff);
      b_s = CMP_W'(bottom_ff);
      h_s = signed'(CMP_W'(h_use));
      w_s = signed'(CMP_W'(w_use));
      culled_c = (l_s >= r_s) || (t_s >= b_s) || (r_s <= 0) || (b_s <= 0) ||
                 (l_s >= w_s) || (t_s >= h_s);
      cl_c = (l_s < 0) ? '0 : CBW'(l_s);
      ct_c = (t_s < 0) ? '0 : RBW'(t_s);
      cr_c = (r_s > w_s) ? w_use : CBW'(r_s);
      cb_c = (b_s > h_s) ? h_use : RBW'(b_s);
      rd_ok_c = (CMP_W'(rrow_ff) < CMP_W'(h_use)) && (CMP_W'(rcol_ff) < CMP_W'(w_use));
   end

   assign req_act  = action_type'(req_tuser);
   assign req_fire = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // Capture the item on its transfer
   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff    <= req_act;
         left_ff   <= req_tdata[10:0];
         top_ff    <= req_tdata[21:11];
         right_ff  <= req_tdata[32:22];
         bottom_ff <= req_tdata[43:33];
         brush_ff  <= req_tdata[51:44];
         rrow_ff   <= req_tdata[57:52];
         rcol_ff   <= req_tdata[65:58];
      end
      if (state_ff == ST_CULL) begin
         culled_ff <= culled_c;
      end
      if (state_ff == ST_READ) begin
         rd_ok_ff <= rd_ok_c;
      end
      if (state_ff == ST_BOOT) begin
         clr_h_ff <= h_rst;
         clr_w_ff <= w_rst;
      end else if (req_fire && (req_act == ACT_CLEAR)) begin
         clr_h_ff <= h_use;
         clr_w_ff <= w_use;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_BOOT: state_in = ST_CLEAR;
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_act)
                  ACT_CLEAR: state_in = ST_CLEAR;
                  ACT_FILL:  state_in = ST_CULL;
                  ACT_READ:  state_in = ST_READ;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_CULL:  state_in = culled_c ? ST_DONE : ST_FILL;
         ST_FILL: begin
            if (walk_sts.last) begin
               state_in = ST_DONE;
            end
         end
         ST_CLEAR: begin
            if (walk_sts.last) begin
               state_in = boot_ff ? ST_IDLE : ST_DONE;
            end
         end
         ST_READ:  state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BOOT;
         boot_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_CLEAR) && walk_sts.last) begin
            boot_ff <= 1'b0;
         end
      end
   end

   // Clear pattern for the cell under the walker
   always_comb begin
      clr_in_map = (walk_row < clr_h_ff) && (walk_col < clr_w_ff);
      clr_water  = clr_in_map && (walk_row >= (clr_h_ff - RBW'(WATER_ROWS)));
   end

   // Sequencer outputs
   always_comb begin
      req_tready     = 1'b0;
      walk_ctl       = '0;
      walk_row_first = '0;
      walk_col_first = '0;
      walk_row_end   = RBW'(MAX_ROWS);
      walk_col_end   = CBW'(MAX_COLS);
      wr_en          = 1'b0;
      wr_data        = BLANK_CHAR;
      rd_en          = 1'b0;
      rsp_load       = 1'b0;
      unique case (state_ff)
         ST_BOOT: walk_ctl.load = 1'b1;
         ST_IDLE: begin
            req_tready    = 1'b1;
            walk_ctl.load = req_tvalid && (req_act == ACT_CLEAR);
         end
         ST_CULL: begin
            walk_ctl.load  = !culled_c;
            walk_row_first = ct_c;
            walk_col_first = cl_c;
            walk_row_end   = cb_c;
            walk_col_end   = cr_c;
         end
         ST_FILL: begin
            walk_ctl.step  = 1'b1;
            walk_ctl.tally = 1'b1;
            wr_en          = 1'b1;
            wr_data        = brush_ff;
         end
         ST_CLEAR: begin
            walk_ctl.step  = 1'b1;
            walk_ctl.tally = clr_in_map;
            wr_en          = 1'b1;
            wr_data        = clr_water ? WATER_CHAR : BLANK_CHAR;
         end
         ST_READ: rd_en = 1'b1;
         ST_DONE: rsp_load = rsp_free;
         default: req_tready = 1'b0;
      endcase
   end

   crf_walk #(
      .ROW_BW (RBW),
      .COL_BW (CBW)
   ) u_walk (
      .clock     (clock),
      .ctl       (walk_ctl),
      .row_first (walk_row_first),
      .col_first (walk_col_first),
      .row_end   (walk_row_end),
      .col_end   (walk_col_end),
      .row       (walk_row),
      .col       (walk_col),
      .count     (walk_count),
      .sts       (walk_sts)
   );

   crf_store #(
      .ADDR_W (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ({walk_row[RW-1:0], walk_col[CW-1:0]}),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr ({RW'(rrow_ff), CW'(rcol_ff)}),
      .rd_data (rd_data)
   );

   // Assemble the result
   always_comb begin
      out_cell  = ((act_ff == ACT_READ) && rd_ok_ff) ? rd_data : '0;
      out_drawn = (act_ff == ACT_FILL) && !culled_ff;
      out_count = ((act_ff == ACT_CLEAR) || out_drawn) ? walk_count : '0;
   end

   // Output register: hold until the result transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {out_count, out_drawn, out_cell};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hdl/crf_checker.sv
// Port-level checker for the rectangle fill block, bound to the top level.
`include "clipped_rectangle_fill_framebuffer_defines.svh"

module crf_checker
   import crf_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // A stalled result stays offered
   `CRF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // One item at a time: no transfer right after a transfer
   `CRF_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready)
   // A drawn rectangle reads no cell
   `CRF_ASSERT_SAME(a_drawn_no_cell, clock, reset, rsp_tvalid && rsp_tdata[8], rsp_tdata[7:0] == 8'd0)
   // A drawn rectangle writes at least one cell
   `CRF_ASSERT_SAME(a_drawn_count, clock, reset, rsp_tvalid && rsp_tdata[8], rsp_tdata[23:9] != 15'd0)

endmodule

bind clipped_rectangle_fill_framebuffer crf_checker u_crf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/sv/tb.sv
// Self-checking testbench of the clipped rectangle fill block, with its own frame store image.
module tb;
   import crf_pkg::*;

   localparam int ROWS         = DEF_MAX_ROWS;
   localparam int COLS         = DEF_MAX_COLS;
   localparam int STALL_LIMIT  = 100000;
   localparam int MAX_REPORTS  = 10;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS  = 106;
   localparam int PHASES       = 8;

   typedef enum int {RX_OPEN, RX_COIN, RX_STARVE, RX_COMB} rx_mode_type;

   typedef struct {
      action_type                act;
      logic signed [COORD_W-1:0] left, top, right, bottom;
      logic [CHAR_W-1:0]         brush;
      logic [READ_ROW_W-1:0]     row;
      logic [READ_COL_W-1:0]     col;
   } draw_item_type;

   typedef struct {
      logic [CHAR_W-1:0]  char_byte;
      logic               drawn;
      logic [COUNT_W-1:0] count;
   } cell_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // req_tdata from bit 0: rect_left, rect_top, rect_right, rect_bottom, brush_char,
   // read_row, read_col, zero fill
   logic [REQ_TDATA_W-1:0] req_tdata;
   // req_tuser: action
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // rsp_tdata from bit 0: cell_char, rect_drawn, cells_written
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // Image of the frame store and of the two map registers
   logic [CHAR_W-1:0]   frame_image [ROWS][COLS];
   logic [HEIGHT_W-1:0] height_reg;
   logic [WIDTH_W-1:0]  width_reg;
   cell_result_type     expected_results[$];

   int burst_left;
   int mismatches;
   int results_checked;
   int items_sent;
   int fills_drawn;
   int fills_culled;
   int clears_done;
   int reads_done;
   int idle_codes;
   int settings_used;
   int idle_cycles;

   clipped_rectangle_fill_framebuffer uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Map size in use: registers saturated to the store size
   function automatic int rows_in_map();
      int h;
      h = int'(height_reg);
      if (h < MIN_ROWS) h = MIN_ROWS;
      if (h > ROWS) h = ROWS;
      return h;
   endfunction

   function automatic int cols_in_map();
      int w;
      w = int'(width_reg);
      if (w < MIN_COLS) w = MIN_COLS;
      if (w > COLS) w = COLS;
      return w;
   endfunction

   function automatic logic [COUNT_W-1:0] clamp_count(int n);
      return (n > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(n);
   endfunction

   // Blank the whole store, then lay the water rows at the bottom of the map
   function automatic int wipe_frame();
      int h, w, r, c;
      h = rows_in_map();
      w = cols_in_map();
      for (r = 0; r < ROWS; r++)
         for (c = 0; c < COLS; c++)
            frame_image[r][c] = BLANK_CHAR;
      for (r = h - WATER_ROWS; r < h; r++)
         for (c = 0; c < w; c++)
            frame_image[r][c] = WATER_CHAR;
      return h * w;
   endfunction

   // Update the store image with one item and return the result it should give
   function automatic cell_result_type apply_draw_item(draw_item_type it);
      cell_result_type res;
      int h, w, l, t, rt, bt, r, c;
      h = rows_in_map();
      w = cols_in_map();
      res.char_byte = '0;
      res.drawn     = 1'b0;
      res.count     = '0;
      case (it.act)
         ACT_CLEAR: res.count = clamp_count(wipe_frame());
         ACT_FILL: begin
            l  = int'(it.left);
            t  = int'(it.top);
            rt = int'(it.right);
            bt = int'(it.bottom);
            if (!(l >= rt || t >= bt || rt <= 0 || bt <= 0 || l >= w || t >= h)) begin
               if (l < 0) l = 0;
               if (t < 0) t = 0;
               if (rt > w) rt = w;
               if (bt > h) bt = h;
               for (r = t; r < bt; r++)
                  for (c = l; c < rt; c++)
                     frame_image[r][c] = it.brush;
               res.drawn = 1'b1;
               res.count = clamp_count((rt - l) * (bt - t));
            end
         end
         ACT_READ: begin
            if (int'(it.row) < h && int'(it.col) < w)
               res.char_byte = frame_image[it.row][it.col];
         end
         default: ;
      endcase
      return res;
   endfunction

   // Item with every field random; callers override what matters
   function automatic draw_item_type scrambled_item(action_type a);
      draw_item_type it;
      it.act    = a;
      it.left   = COORD_W'($urandom);
      it.top    = COORD_W'($urandom);
      it.right  = COORD_W'($urandom);
      it.bottom = COORD_W'($urandom);
      it.brush  = CHAR_W'($urandom);
      it.row    = READ_ROW_W'($urandom);
      it.col    = READ_COL_W'($urandom);
      return it;
   endfunction

   function automatic draw_item_type fill_item(int l, int t, int r, int b,
                                               logic [CHAR_W-1:0] brush);
      draw_item_type it;
      it        = scrambled_item(ACT_FILL);
      it.left   = COORD_W'(l);
      it.top    = COORD_W'(t);
      it.right  = COORD_W'(r);
      it.bottom = COORD_W'(b);
      it.brush  = brush;
      return it;
   endfunction

   function automatic draw_item_type read_item(int row, int col);
      draw_item_type it;
      it     = scrambled_item(ACT_READ);
      it.row = READ_ROW_W'(row);
      it.col = READ_COL_W'(col);
      return it;
   endfunction

   // Mostly well-formed fills and in-map reads, with rare clears and some noise
   function automatic draw_item_type random_item();
      draw_item_type it;
      int h, w, pick, l, t, r, b;
      h    = rows_in_map();
      w    = cols_in_map();
      pick = $urandom_range(0, 199);
      it   = scrambled_item(ACT_READ);
      if (pick < 2) begin
         it.act = ACT_CLEAR;
      end else if (pick < 8) begin
         it.act = ACT_NONE;
      end else if (pick < 18) begin
         // wild coordinates over the whole signed range
         it.act = ACT_FILL;
      end else if (pick < 118) begin
         it.act = ACT_FILL;
         l = int'($urandom_range(0, w + 10)) - 6;
         t = int'($urandom_range(0, h + 6)) - 4;
         if (pick < 23) begin
            // sweeping rectangle, often past the map edges
            r = l + int'($urandom_range(w / 2, w + 20));
            b = t + int'($urandom_range(h / 2, h + 8));
         end else if (pick < 38) begin
            // empty or inverted rectangle
            if ($urandom_range(0, 1) == 1) begin
               r = l - int'($urandom_range(0, 6));
               b = t + int'($urandom_range(1, 12));
            end else begin
               r = l + int'($urandom_range(1, 20));
               b = t - int'($urandom_range(0, 6));
            end
         end else begin
            r = l + int'($urandom_range(1, 20));
            b = t + int'($urandom_range(1, 12));
         end
         it.left   = COORD_W'(l);
         it.top    = COORD_W'(t);
         it.right  = COORD_W'(r);
         it.bottom = COORD_W'(b);
      end else if (pick < 176) begin
         it.row = READ_ROW_W'($urandom_range(0, h - 1));
         it.col = READ_COL_W'($urandom_range(0, w - 1));
      end
      return it;
   endfunction

   function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch on %s at result %0d: expected %0h, got %0h",
                  what, results_checked, want, got);
   endfunction

   // Offer one item in bursts with random gaps; predict it on its transfer
   task automatic send_item(draw_item_type it);
      cell_result_type res;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      burst_left--;
      req_tuser  = it.act;
      req_tdata  = REQ_TDATA_W'({it.col, it.row, it.brush, it.bottom, it.right, it.top,
                                 it.left});
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      res = apply_draw_item(it);
      expected_results = {expected_results, res};
      items_sent++;
      case (it.act)
         ACT_CLEAR: clears_done++;
         ACT_FILL: begin
            if (res.drawn) fills_drawn++;
            else fills_culled++;
         end
         ACT_READ:  reads_done++;
         default:   idle_codes++;
      endcase
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic csr_read(reg_index_type idx, output logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = {idx, 2'b00};
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      value = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // Hold until every result is back and the block has settled
   task automatic wait_idle();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both map registers with random upper bits, then read them back
   task automatic configure_map(int h_raw, int w_raw);
      logic [CSR_DATA_W-1:0] word, back;
      word                 = $urandom;
      word[HEIGHT_W-1:0]   = HEIGHT_W'(h_raw);
      csr_write(REG_MAP_HEIGHT, word);
      height_reg           = word[HEIGHT_W-1:0];
      word                 = $urandom;
      word[WIDTH_W-1:0]    = WIDTH_W'(w_raw);
      csr_write(REG_MAP_WIDTH, word);
      width_reg            = word[WIDTH_W-1:0];
      csr_read(REG_MAP_HEIGHT, back);
      if (back !== CSR_DATA_W'(height_reg))
         flag_mismatch("map_height readback", 32'(height_reg), back);
      csr_read(REG_MAP_WIDTH, back);
      if (back !== CSR_DATA_W'(width_reg))
         flag_mismatch("map_width readback", 32'(width_reg), back);
      settings_used++;
   endtask

   // Contents left by the boot sweep on the reset map
   task automatic test_reset_image();
      send_item(read_item(ROWS - 1, 0));
      send_item(read_item(ROWS - WATER_ROWS, COLS - 1));
      send_item(read_item(ROWS - WATER_ROWS - 1, COLS - 1));
      send_item(read_item(0, 0));
   endtask

   // Each way a rectangle is dropped before any cell is written
   task automatic test_fill_culling();
      send_item(fill_item(5, 0, 5, 10, 8'h41));
      send_item(fill_item(0, 9, 10, 3, 8'h42));
      send_item(fill_item(-1024, 0, 0, 10, 8'h43));
      send_item(fill_item(0, -1024, 10, 0, 8'h44));
      send_item(fill_item(COLS, 0, 1023, 10, 8'h45));
      send_item(fill_item(0, ROWS, 10, 1023, 8'h46));
   endtask

   // Clipping on every edge, a single cell, the whole map and the unused code
   task automatic test_fill_clipping();
      send_item(fill_item(-1024, -1024, 3, 2, 8'hFF));
      send_item(fill_item(COLS - 6, ROWS - 4, 1023, 1023, 8'h00));
      send_item(fill_item(10, 10, 11, 11, 8'h41));
      send_item(read_item(0, 0));
      send_item(read_item(ROWS - 1, COLS - 1));
      send_item(read_item(10, 10));
      send_item(scrambled_item(ACT_NONE));
      send_item(fill_item(-1024, -1024, 1023, 1023, 8'h2A));
      send_item(read_item(ROWS / 2, COLS / 2));
   endtask

   // Registers below their floor; reads and fills outside the smallest map
   task automatic test_register_limits();
      wait_idle();
      configure_map(0, 0);
      send_item(scrambled_item(ACT_CLEAR));
      send_item(read_item(2, 0));
      send_item(read_item(3, 0));
      send_item(read_item(0, 1));
      send_item(fill_item(-1, -1, 5, 5, 8'h55));
   endtask

   // Random traffic over a series of map settings, extremes among them
   task automatic test_random_traffic();
      int p, h, w;
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: begin h = 64;  w = 256; end
            1: begin h = 3;   w = 1;   end
            2: begin h = 127; w = 511; end
            3: begin h = 0;   w = 0;   end
            4: begin h = 64;  w = 1;   end
            5: begin h = 3;   w = 256; end
            6: begin h = $urandom_range(3, 64); w = $urandom_range(1, 256); end
            default: begin h = $urandom_range(0, 127); w = $urandom_range(0, 511); end
         endcase
         wait_idle();
         configure_map(h, w);
         if ($urandom_range(0, 1) == 1) send_item(scrambled_item(ACT_CLEAR));
         repeat (PHASE_ITEMS) send_item(random_item());
      end
   endtask

   // Receiver: ready pattern changes mode at random
   initial begin
      rx_mode_type mode;
      int span, tick;
      rsp_tready = 1'b0;
      tick       = 0;
      forever begin
         mode = rx_mode_type'($urandom_range(0, 3));
         span = $urandom_range(50, 400);
         repeat (span) begin
            @(negedge clock);
            tick++;
            case (mode)
               RX_OPEN:   rsp_tready = 1'b1;
               RX_COIN:   rsp_tready = ($urandom_range(0, 1) == 1);
               RX_STARVE: rsp_tready = ($urandom_range(0, 7) == 0);
               default:   rsp_tready = ((tick % 7) >= 3);
            endcase
         end
      end
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      cell_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            flag_mismatch("result with nothing expected", '0, 32'(rsp_tdata));
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[7:0] !== want.char_byte)
               flag_mismatch("cell_char", 32'(want.char_byte), 32'(rsp_tdata[7:0]));
            if (rsp_tdata[8] !== want.drawn)
               flag_mismatch("rect_drawn", 32'(want.drawn), 32'(rsp_tdata[8]));
            if (rsp_tdata[23:9] !== want.count)
               flag_mismatch("cells_written", 32'(want.count), 32'(rsp_tdata[23:9]));
         end
         results_checked++;
      end
   end

   // Watchdog: end the run when no transfer happens for too long
   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_results.size());
      $display("simulation failed");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      burst_left      = 0;
      mismatches      = 0;
      results_checked = 0;
      items_sent      = 0;
      fills_drawn     = 0;
      fills_culled    = 0;
      clears_done     = 0;
      reads_done      = 0;
      idle_codes      = 0;
      settings_used   = 1;
      height_reg      = HEIGHT_RST;
      width_reg       = WIDTH_RST;
      void'(wipe_frame());
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_image();
      test_fill_culling();
      test_fill_clipping();
      test_register_limits();
      test_random_traffic();

      // Drain the remaining results, then let the block settle
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES * 4) @(posedge clock);

      $display("sent %0d items: %0d fills drawn, %0d culled, %0d clears, %0d reads, %0d unused",
               items_sent, fills_drawn, fills_culled, clears_done, reads_done, idle_codes);
      $display("checked %0d results over %0d map settings, %0d mismatches",
               results_checked, settings_used, mismatches);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
